// ===== rtl/rlcf_pkg.sv =====
package rlcf_pkg;

   localparam int LEVEL_BITS   = 8;
   localparam int NUM_CHAN     = 4;
   localparam int CHAN_BITS    = 2;
   localparam int STEP_BITS    = 17;
   localparam int RATE_BITS    = 8;
   localparam int T_BITS       = 2 * RATE_BITS;
   localparam int PROD_BITS    = T_BITS + LEVEL_BITS;
   localparam int DIV_CNT_BITS = $clog2(LEVEL_BITS);
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [RATE_BITS-1:0] FPS_RESET = 8'd30;
   localparam logic [RATE_BITS-1:0] DUR_RESET = 8'd2;

   localparam logic CSR_FPS = 1'b0;
   localparam logic CSR_DUR = 1'b1;

   localparam logic [1:0] KIND_TICK   = 2'd0;
   localparam logic [1:0] KIND_TARGET = 2'd1;
   localparam logic [1:0] KIND_START  = 2'd2;
   localparam logic [1:0] KIND_STOP   = 2'd3;

   localparam logic [2:0] OP_TICK_END   = 3'd0;
   localparam logic [2:0] OP_TICK_FRAME = 3'd1;
   localparam logic [2:0] OP_TARGET     = 3'd2;
   localparam logic [2:0] OP_START      = 3'd3;
   localparam logic [2:0] OP_STOP       = 3'd4;

   typedef logic [NUM_CHAN-1:0][LEVEL_BITS-1:0] color_type;

   typedef struct packed {
      logic [1:0]            kind;
      logic [LEVEL_BITS-1:0] red_in;
      logic [LEVEL_BITS-1:0] green_in;
      logic [LEVEL_BITS-1:0] blue_in;
      logic [LEVEL_BITS-1:0] white_in;
   } req_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] red_out;
      logic [LEVEL_BITS-1:0] green_out;
      logic [LEVEL_BITS-1:0] blue_out;
      logic [LEVEL_BITS-1:0] white_out;
      logic                  fade_done;
   } rsp_type;

   typedef struct packed {
      logic       capture;
      logic       setup;
      logic       mul;
      logic       load;
      logic       div_step;
      logic       commit;
      logic       emit;
      logic       dur_reset;
      logic [2:0] op;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       fading;
      logic       enabled;
      logic       over;
      logic       div_last;
      logic       chan_last;
      logic       slot_free;
   } stat_type;

endpackage

// ===== rtl/rlcf_ctrl.sv =====
module rlcf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rlcf_pkg::stat_type stat,
   output rlcf_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SETUP  = 3'd1;
   localparam logic [2:0] S_MUL    = 3'd2;
   localparam logic [2:0] S_LOAD   = 3'd3;
   localparam logic [2:0] S_DIV    = 3'd4;
   localparam logic [2:0] S_COMMIT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic       has_res;

   assign req_ready = (state_ff == S_IDLE);

   assign has_res = (op_ff != rlcf_pkg::OP_STOP)
                  && ((op_ff != rlcf_pkg::OP_TARGET) || stat.enabled);

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      cmd.op   = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_SETUP;
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            unique case (stat.kind)
               rlcf_pkg::KIND_TICK: begin
                  if (!stat.fading) begin
                     state_in = S_IDLE;
                  end else if (stat.over) begin
                     op_in    = rlcf_pkg::OP_TICK_END;
                     state_in = S_COMMIT;
                  end else begin
                     op_in    = rlcf_pkg::OP_TICK_FRAME;
                     state_in = S_MUL;
                  end
               end
               rlcf_pkg::KIND_TARGET: begin
                  op_in    = rlcf_pkg::OP_TARGET;
                  state_in = stat.fading ? S_MUL : S_COMMIT;
               end
               rlcf_pkg::KIND_START: begin
                  op_in    = rlcf_pkg::OP_START;
                  state_in = S_COMMIT;
               end
               default: begin
                  op_in    = rlcf_pkg::OP_STOP;
                  state_in = S_COMMIT;
               end
            endcase
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = stat.chan_last ? S_COMMIT : S_MUL;
            end
         end
         S_COMMIT: begin
            if (!has_res || stat.slot_free) begin
               cmd.commit    = 1'b1;
               cmd.emit      = has_res;
               cmd.dur_reset = (op_ff == rlcf_pkg::OP_START);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= rlcf_pkg::OP_STOP;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

`ifndef SYNTH
   a_accept_to_setup: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_SETUP))
      else $error("accepted beat did not move to setup");

   a_emit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (stat.slot_free && cmd.commit))
      else $error("result written while output slot busy");
`endif

endmodule

// ===== rtl/rlcf_dpath.sv =====
module rlcf_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rlcf_pkg::req_type                    req_payload,
   input  rlcf_pkg::cmd_type                    cmd,
   output rlcf_pkg::stat_type                   stat,
   input  logic [rlcf_pkg::RATE_BITS-1:0]       fps,
   input  logic [rlcf_pkg::RATE_BITS-1:0]       dur,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output rlcf_pkg::rsp_type                    rsp_payload
);

   localparam int L  = rlcf_pkg::LEVEL_BITS;
   localparam int TB = rlcf_pkg::T_BITS;
   localparam int PB = rlcf_pkg::PROD_BITS;
   localparam int SB = rlcf_pkg::STEP_BITS;
   localparam int RB = rlcf_pkg::RATE_BITS;
   localparam int CB = rlcf_pkg::CHAN_BITS;
   localparam int DB = rlcf_pkg::DIV_CNT_BITS;

   logic [1:0]          kind_ff, kind_in;
   rlcf_pkg::color_type col_ff, col_in;
   rlcf_pkg::color_type start_ff, start_in;
   rlcf_pkg::color_type target_ff, target_in;
   rlcf_pkg::color_type blend_ff, blend_in;
   logic [SB-1:0]       step_ff, step_in;
   logic                fading_ff, fading_in;
   logic                enabled_ff, enabled_in;
   logic [TB-1:0]       t_ff, t_in;
   logic [TB-1:0]       s_ff, s_in;
   logic [CB-1:0]       ch_ff, ch_in;
   logic [PB-1:0]       prod_a_ff, prod_a_in;
   logic [PB-1:0]       prod_b_ff, prod_b_in;
   logic [TB-1:0]       rem_ff, rem_in;
   logic [L-1:0]        lo_ff, lo_in;
   logic [L-1:0]        quot_ff, quot_in;
   logic [DB-1:0]       cnt_ff, cnt_in;
   rlcf_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [RB-1:0]       fps_nz, dur_nz;
   logic [TB-1:0]       t_comb;
   logic                over;
   logic [PB-1:0]       diff_w, s_w, a_w, b_w, sum_w;
   logic [TB:0]         trial, trial_sub;
   logic                ge;
   logic                div_last;
   rlcf_pkg::color_type base;
   rlcf_pkg::color_type res_col;
   logic                res_done;

   assign fps_nz = (fps == '0) ? RB'(1) : fps;
   assign dur_nz = (dur == '0) ? RB'(1) : dur;
   assign t_comb = {{RB{1'b0}}, fps_nz} * {{RB{1'b0}}, dur_nz};
   assign over   = step_ff > {1'b0, t_comb};

   assign diff_w = {{L{1'b0}}, t_ff - s_ff};
   assign s_w    = {{L{1'b0}}, s_ff};
   assign a_w    = {{TB{1'b0}}, start_ff[ch_ff]};
   assign b_w    = {{TB{1'b0}}, target_ff[ch_ff]};
   assign sum_w  = prod_a_ff + prod_b_ff;

   assign trial     = {rem_ff, lo_ff[L-1]};
   assign trial_sub = trial - {1'b0, t_ff};
   assign ge        = trial >= {1'b0, t_ff};
   assign div_last  = (cnt_ff == DB'(L - 1));

   assign base = fading_ff ? blend_ff : start_ff;

   assign stat.kind      = kind_ff;
   assign stat.fading    = fading_ff;
   assign stat.enabled   = enabled_ff;
   assign stat.over      = over;
   assign stat.div_last  = div_last;
   assign stat.chan_last = (ch_ff == CB'(rlcf_pkg::NUM_CHAN - 1));
   assign stat.slot_free = !rsp_valid_ff || rsp_ready;

   // datapath for one item: capture, setup, per-channel multiply, load, divide
   always_comb begin
      kind_in   = kind_ff;
      col_in    = col_ff;
      t_in      = t_ff;
      s_in      = s_ff;
      ch_in     = ch_ff;
      prod_a_in = prod_a_ff;
      prod_b_in = prod_b_ff;
      rem_in    = rem_ff;
      lo_in     = lo_ff;
      quot_in   = quot_ff;
      cnt_in    = cnt_ff;
      blend_in  = blend_ff;
      if (cmd.capture) begin
         kind_in   = req_payload.kind;
         col_in[0] = req_payload.red_in;
         col_in[1] = req_payload.green_in;
         col_in[2] = req_payload.blue_in;
         col_in[3] = req_payload.white_in;
      end
      if (cmd.setup) begin
         t_in  = t_comb;
         s_in  = over ? t_comb : step_ff[TB-1:0];
         ch_in = '0;
      end
      if (cmd.mul) begin
         prod_a_in = diff_w * a_w;
         prod_b_in = s_w * b_w;
      end
      if (cmd.load) begin
         rem_in  = sum_w[PB-1:L];
         lo_in   = sum_w[L-1:0];
         quot_in = '0;
         cnt_in  = '0;
      end
      if (cmd.div_step) begin
         rem_in  = ge ? trial_sub[TB-1:0] : trial[TB-1:0];
         lo_in   = {lo_ff[L-2:0], 1'b0};
         quot_in = {quot_ff[L-2:0], ge};
         cnt_in  = cnt_ff + DB'(1);
         if (div_last) begin
            blend_in[ch_ff] = {quot_ff[L-2:0], ge};
            ch_in           = ch_ff + CB'(1);
         end
      end
   end

   // state update and result
   always_comb begin
      start_in     = start_ff;
      target_in    = target_ff;
      step_in      = step_ff;
      fading_in    = fading_ff;
      enabled_in   = enabled_ff;
      res_col      = blend_ff;
      res_done     = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.commit) begin
         unique case (cmd.op)
            rlcf_pkg::OP_TICK_END: begin
               start_in  = target_ff;
               target_in = '0;
               fading_in = 1'b0;
               step_in   = '0;
               res_col   = target_ff;
               res_done  = 1'b1;
            end
            rlcf_pkg::OP_TICK_FRAME: begin
               step_in = step_ff + SB'(1);
               res_col = blend_ff;
            end
            rlcf_pkg::OP_TARGET: begin
               res_col = base;
               if (enabled_ff) begin
                  start_in  = base;
                  target_in = col_ff;
                  fading_in = 1'b1;
                  step_in   = SB'(1);
               end else begin
                  start_in  = col_ff;
                  fading_in = 1'b0;
                  step_in   = '0;
               end
            end
            rlcf_pkg::OP_START: begin
               target_in  = start_ff;
               start_in   = '0;
               enabled_in = 1'b1;
               fading_in  = 1'b1;
               step_in    = SB'(1);
               res_col    = '0;
            end
            rlcf_pkg::OP_STOP: begin
               if (fading_ff) begin
                  start_in  = target_ff;
                  target_in = '0;
                  fading_in = 1'b0;
                  step_in   = '0;
               end
               enabled_in = 1'b0;
            end
            default: begin
               res_col = blend_ff;
            end
         endcase
      end
      if (cmd.emit) begin
         rsp_in.red_out   = res_col[0];
         rsp_in.green_out = res_col[1];
         rsp_in.blue_out  = res_col[2];
         rsp_in.white_out = res_col[3];
         rsp_in.fade_done = res_done;
         rsp_valid_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      col_ff    <= col_in;
      t_ff      <= t_in;
      s_ff      <= s_in;
      ch_ff     <= ch_in;
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      rem_ff    <= rem_in;
      lo_ff     <= lo_in;
      quot_ff   <= quot_in;
      cnt_ff    <= cnt_in;
      blend_ff  <= blend_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= '0;
         target_ff    <= '0;
         step_ff      <= '0;
         fading_ff    <= 1'b0;
         enabled_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         target_ff    <= target_in;
         step_ff      <= step_in;
         fading_ff    <= fading_in;
         enabled_ff   <= enabled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   a_fade_needs_enable: assert property (@(posedge clock) disable iff (reset)
      fading_ff |-> enabled_ff)
      else $error("fade running while disabled");

   a_idle_step_zero: assert property (@(posedge clock) disable iff (reset)
      !fading_ff |-> (step_ff == '0))
      else $error("step count nonzero with no fade");
`endif

endmodule

// ===== rtl/rgbw_linear_crossfade_core.sv =====
// channel   direction   handshake                         payload
// req       in          req_valid / req_ready             req_payload (rlcf_pkg::req_type)
// rsp       out         rsp_valid / rsp_ready             rsp_payload (rlcf_pkg::rsp_type)
// csr       in/out      psel, penable, pwrite, pready     paddr, pwdata, prdata
//
// a frame tick mid-fade or a new target during a fade multiplies and divides each channel,
// using the 8-step restoring divider shared by the four channels in turn
// start, stop, idle target, final tick go to commit; a tick with no fade ends at setup
// reset is synchronous and active high; state, flags and rates return to defaults
// the output register holds a result until taken; a new beat is accepted meanwhile
// and stalls only when its own result finds the output register still full
module rgbw_linear_crossfade_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  rlcf_pkg::req_type                     req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output rlcf_pkg::rsp_type                     rsp_payload,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [rlcf_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [rlcf_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [rlcf_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                  pready
);

   localparam int RB = rlcf_pkg::RATE_BITS;
   localparam int DW = rlcf_pkg::CSR_DATA_BITS;

   rlcf_pkg::cmd_type  cmd;
   rlcf_pkg::stat_type stat;

   logic [RB-1:0] fps_ff, fps_in;
   logic [RB-1:0] dur_ff, dur_in;
   logic          csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      fps_in = fps_ff;
      dur_in = dur_ff;
      if (cmd.dur_reset) begin
         dur_in = rlcf_pkg::DUR_RESET;
      end
      if (csr_wr) begin
         unique case (paddr[2])
            rlcf_pkg::CSR_FPS: fps_in = pwdata[RB-1:0];
            rlcf_pkg::CSR_DUR: dur_in = pwdata[RB-1:0];
            default: fps_in = fps_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         rlcf_pkg::CSR_FPS: prdata = {{(DW - RB){1'b0}}, fps_ff};
         rlcf_pkg::CSR_DUR: prdata = {{(DW - RB){1'b0}}, dur_ff};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fps_ff <= rlcf_pkg::FPS_RESET;
         dur_ff <= rlcf_pkg::DUR_RESET;
      end else begin
         fps_ff <= fps_in;
         dur_ff <= dur_in;
      end
   end

   rlcf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rlcf_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .fps         (fps_ff),
      .dur         (dur_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
